FILE: design/hlfs_pkg.sv
// Shared types, constants and the log-sum correction table for the
// log-space HMM forward step. No dependencies; every other file imports it.

package hlfs_pkg;

    localparam int MAX_STATES   = 16;
    localparam int LOG_WIDTH    = 32;
    localparam int CORR_ENTRIES = 256;

    localparam int ST_W     = $clog2(MAX_STATES);
    localparam int TR_AW    = 2 * ST_W;
    localparam int NS_W     = 5;
    localparam int CORR_AW  = $clog2(CORR_ENTRIES);
    localparam int CORR_W   = 16;
    // Differences of 16.0 and more (Q12) get no correction.
    localparam int SPAN_W   = 16;

    localparam logic signed [LOG_WIDTH-1:0] NEG_INF = {1'b1, {(LOG_WIDTH-1){1'b0}}};
    localparam logic signed [LOG_WIDTH-1:0] MAXV    = {1'b0, {(LOG_WIDTH-1){1'b1}}};

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    typedef enum logic [1:0] {
        KIND_TRANS = 2'd0,
        KIND_INIT  = 2'd1,
        KIND_EMIT  = 2'd2
    } t_kind;

    typedef logic [CORR_W-1:0] t_corr_tab [CORR_ENTRIES];

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            load_trans;
        logic            load_init;
        logic            start;
        logic            issue;
        logic [ST_W-1:0] rd_idx;
        logic            emit;
        logic            finish;
        logic            is_last;
        logic            out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // Shift-and-subtract quotient; only evaluated while the table below is built.
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(1+exp(-x)) at the midpoint of bin k, in Q12, evaluated in Q30 integer series.
    function automatic logic [CORR_W-1:0] corr_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        n;
        logic [63:0]        r;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        y;
        logic [63:0]        z;
        logic [63:0]        z2;
        logic [63:0]        p;
        logic [63:0]        s;
        logic [63:0]        res;
        x    = (64'(2 * k + 1) << 33) >> CORR_AW;
        n    = div_u64(x, LN2_Q30);
        r    = x - n * LN2_Q30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        s    = 64'd0;
        for (int i = 1; i <= 12; i++) begin
            term = div_u64((term * r) >> 30, 64'(i));
            if ((i & 1) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        y  = (n < 64'd62) ? (64'(sum) >> n) : 64'd0;
        z  = div_u64(y << 30, (ONE_Q30 << 1) + y);
        z2 = (z * z) >> 30;
        p  = z;
        for (int i = 1; i <= 19; i += 2) begin
            s = s + div_u64(p, 64'(i));
            p = (p * z2) >> 30;
        end
        res = ((s << 1) + (64'd1 << 17)) >> 18;
        return res[CORR_W-1:0];
    endfunction

    function automatic t_corr_tab corr_build();
        t_corr_tab t;
        for (int k = 0; k < CORR_ENTRIES; k++) begin
            t[k] = corr_entry(k);
        end
        return t;
    endfunction

    localparam t_corr_tab CORR_TAB = corr_build();

endpackage

FILE: design/hmm_log_forward_step.sv
// Log-space HMM forward step. A load gives no result; the input stays ready.
// An emission steps through S_EMIT, S_FIN and S_OUT; a later step first makes
// one transition read per source state (S_ACC) and drains (S_DRN1, S_DRN2). No
// new item is taken before the step is done; S_OUT loads the output register.
// A result not yet taken holds off the input until the output register frees.
// Sync active-low reset: num_states 16, likelihood minus infinity, tables undefined.

module hmm_log_forward_step
    import hlfs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // from_state[3:0], to_state[7:4], log_value[39:8], first_step[40], final_step[41], zeros
    input  logic [47:0]      i_s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]       i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // out_state[3:0], alpha[35:4], log_likelihood[67:36], zeros
    output logic [71:0]      o_m_axis_tdata,
    // likelihood_valid[0]
    output logic             o_m_axis_tuser,
    input  logic             i_cfg_we,
    input  logic [NS_W-1:0]  i_cfg_wdata
);

    t_cmd                        cmd;
    t_status                     status;
    logic [ST_W-1:0]             out_state;
    logic signed [LOG_WIDTH-1:0] out_alpha;
    logic signed [LOG_WIDTH-1:0] out_lik;

    hlfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_kind      (i_s_axis_tuser),
        .i_to        (i_s_axis_tdata[7:4]),
        .i_first     (i_s_axis_tdata[40]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (status),
        .o_ready     (o_s_axis_tready),
        .o_cmd       (cmd)
    );

    hlfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_from      (i_s_axis_tdata[3:0]),
        .i_to        (i_s_axis_tdata[7:4]),
        .i_value     (i_s_axis_tdata[39:8]),
        .i_first     (i_s_axis_tdata[40]),
        .i_final     (i_s_axis_tdata[41]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_state     (out_state),
        .o_alpha     (out_alpha),
        .o_lik       (out_lik),
        .o_lik_valid (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {4'b0, out_lik, out_alpha, out_state};

endmodule

FILE: design/hlfs_ctrl.sv
// Controller of the HMM forward step: sequences loads and emissions and
// holds the num_states register. Depends on hlfs_pkg.

module hlfs_ctrl
    import hlfs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_kind,
    input  logic [ST_W-1:0] i_to,
    input  logic            i_first,
    input  logic            i_cfg_we,
    input  logic [NS_W-1:0] i_cfg_wdata,
    input  t_status         i_status,
    output logic            o_ready,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DRN1,
        S_DRN2,
        S_EMIT,
        S_FIN,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [ST_W-1:0] r_cnt;
    logic            r_last;
    logic [NS_W-1:0] r_num_states;

    logic [NS_W-1:0] n_use;
    logic            accept;
    logic            emit_ok;

    always_comb begin
        if (r_num_states == '0) begin
            n_use = NS_W'(1);
        end else if (r_num_states > NS_W'(MAX_STATES)) begin
            n_use = NS_W'(MAX_STATES);
        end else begin
            n_use = r_num_states;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign emit_ok = (i_kind == KIND_EMIT) && ({1'b0, i_to} < n_use);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_last       <= 1'b0;
            r_num_states <= NS_W'(MAX_STATES);
        end else begin
            if (i_cfg_we) begin
                r_num_states <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && emit_ok) begin
                        r_last <= ({1'b0, i_to} == n_use - NS_W'(1));
                        r_cnt  <= '0;
                        r_state <= i_first ? S_EMIT : S_ACC;
                    end
                end
                S_ACC: begin
                    if ({1'b0, r_cnt} == n_use - NS_W'(1)) begin
                        r_state <= S_DRN1;
                    end else begin
                        r_cnt <= r_cnt + ST_W'(1);
                    end
                end
                S_DRN1: r_state <= S_DRN2;
                S_DRN2: r_state <= S_EMIT;
                S_EMIT: r_state <= S_FIN;
                S_FIN:  r_state <= S_OUT;
                S_OUT: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.load_trans = accept && (i_kind == KIND_TRANS);
        o_cmd.load_init  = accept && (i_kind == KIND_INIT);
        o_cmd.start      = accept && emit_ok;
        o_cmd.issue      = (r_state == S_ACC);
        o_cmd.rd_idx     = r_cnt;
        o_cmd.emit       = (r_state == S_EMIT);
        o_cmd.finish     = (r_state == S_FIN);
        o_cmd.is_last    = r_last;
        o_cmd.out_load   = (r_state == S_OUT) && i_status.out_free;
    end

endmodule

FILE: design/hlfs_dp.sv
// Datapath of the HMM forward step: tables, alpha banks, log-product and
// shared log-sum unit, likelihood accumulator and output register. Depends on hlfs_pkg.

module hlfs_dp
    import hlfs_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    input  logic [ST_W-1:0]             i_from,
    input  logic [ST_W-1:0]             i_to,
    input  logic signed [LOG_WIDTH-1:0] i_value,
    input  logic                        i_first,
    input  logic                        i_final,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [ST_W-1:0]             o_state,
    output logic signed [LOG_WIDTH-1:0] o_alpha,
    output logic signed [LOG_WIDTH-1:0] o_lik,
    output logic                        o_lik_valid
);

    function automatic logic signed [LOG_WIDTH-1:0] sat(input logic signed [LOG_WIDTH:0] s);
        logic signed [LOG_WIDTH-1:0] v;
        v = s[LOG_WIDTH-1:0];
        if (s[LOG_WIDTH] != s[LOG_WIDTH-1]) begin
            v = s[LOG_WIDTH] ? (NEG_INF + LOG_WIDTH'(1)) : MAXV;
        end else if (v == NEG_INF) begin
            v = NEG_INF + LOG_WIDTH'(1);
        end
        return v;
    endfunction

    function automatic logic signed [LOG_WIDTH-1:0] lprod(
        input logic signed [LOG_WIDTH-1:0] a,
        input logic signed [LOG_WIDTH-1:0] b
    );
        logic signed [LOG_WIDTH:0] s;
        s = {a[LOG_WIDTH-1], a} + {b[LOG_WIDTH-1], b};
        if (a == NEG_INF || b == NEG_INF) begin
            return NEG_INF;
        end
        return sat(s);
    endfunction

    // max plus a correction looked up on the distance between the operands.
    function automatic logic signed [LOG_WIDTH-1:0] lsum(
        input logic signed [LOG_WIDTH-1:0] a,
        input logic signed [LOG_WIDTH-1:0] b
    );
        logic signed [LOG_WIDTH:0]   diff;
        logic signed [LOG_WIDTH-1:0] hi;
        logic signed [LOG_WIDTH-1:0] lo;
        logic [LOG_WIDTH:0]          d;
        logic [CORR_W-1:0]           c;
        logic signed [LOG_WIDTH:0]   s;
        diff = {a[LOG_WIDTH-1], a} - {b[LOG_WIDTH-1], b};
        hi   = (diff > 0) ? a : b;
        lo   = (diff > 0) ? b : a;
        d    = {hi[LOG_WIDTH-1], hi} - {lo[LOG_WIDTH-1], lo};
        c    = (d < (LOG_WIDTH + 1)'(1) << SPAN_W) ? CORR_TAB[d[SPAN_W-1 -: CORR_AW]] : '0;
        s    = {hi[LOG_WIDTH-1], hi} + (LOG_WIDTH + 1)'(c);
        if (a == NEG_INF) begin
            return b;
        end
        if (b == NEG_INF) begin
            return a;
        end
        return sat(s);
    endfunction

    logic signed [LOG_WIDTH-1:0] r_trans_mem  [MAX_STATES * MAX_STATES];
    logic signed [LOG_WIDTH-1:0] r_init_tab   [MAX_STATES];
    logic signed [LOG_WIDTH-1:0] r_alpha_prev [MAX_STATES];
    logic signed [LOG_WIDTH-1:0] r_alpha_cur  [MAX_STATES];

    logic [ST_W-1:0]             r_to;
    logic signed [LOG_WIDTH-1:0] r_val;
    logic                        r_first;
    logic                        r_final;
    logic signed [LOG_WIDTH-1:0] r_init_rd;
    logic signed [LOG_WIDTH-1:0] r_trans_rd;
    logic signed [LOG_WIDTH-1:0] r_alpha_rd;
    logic signed [LOG_WIDTH-1:0] r_prod;
    logic signed [LOG_WIDTH-1:0] r_acc;
    logic signed [LOG_WIDTH-1:0] r_a;
    logic signed [LOG_WIDTH-1:0] r_lik;
    logic                        r_v1;
    logic                        r_v2;
    logic signed [LOG_WIDTH-1:0] r_res_lik;
    logic                        r_res_valid;
    logic                        r_out_valid;
    logic [ST_W-1:0]             r_out_state;
    logic signed [LOG_WIDTH-1:0] r_out_alpha;
    logic signed [LOG_WIDTH-1:0] r_out_lik;
    logic                        r_out_lik_valid;

    logic signed [LOG_WIDTH-1:0] lik_base;
    logic signed [LOG_WIDTH-1:0] sum_a;
    logic signed [LOG_WIDTH-1:0] sum_b;
    logic signed [LOG_WIDTH-1:0] sum_y;

    // The accumulation and the likelihood update never run in the same cycle.
    assign lik_base = (r_to == '0) ? NEG_INF : r_lik;
    assign sum_a    = i_cmd.finish ? lik_base : r_acc;
    assign sum_b    = i_cmd.finish ? r_a : r_prod;
    assign sum_y    = lsum(sum_a, sum_b);

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_trans) begin
            r_trans_mem[{i_from, i_to}] <= i_value;
        end
        if (i_cmd.issue) begin
            r_trans_rd <= r_trans_mem[{i_cmd.rd_idx, r_to}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_init) begin
            r_init_tab[i_to] <= i_value;
        end
        if (i_cmd.start) begin
            r_init_rd <= r_init_tab[i_to];
            r_to      <= i_to;
            r_val     <= i_value;
            r_first   <= i_first;
            r_final   <= i_final;
        end
        if (i_cmd.issue) begin
            r_alpha_rd <= r_alpha_prev[i_cmd.rd_idx];
        end
        // The current alphas stay in place; the last state copies them to the previous set.
        if (i_cmd.finish) begin
            r_alpha_cur[r_to] <= r_a;
            if (i_cmd.is_last) begin
                for (int k = 0; k < MAX_STATES; k++) begin
                    r_alpha_prev[k] <= (ST_W'(k) == r_to) ? r_a : r_alpha_cur[k];
                end
            end
        end
        r_prod <= lprod(r_alpha_rd, r_trans_rd);
        if (i_cmd.start) begin
            r_acc <= NEG_INF;
        end else if (r_v2) begin
            r_acc <= sum_y;
        end
        if (i_cmd.emit) begin
            r_a <= lprod(r_first ? r_init_rd : r_acc, r_val);
        end
        if (i_cmd.finish) begin
            r_res_lik <= (r_final && i_cmd.is_last) ? sum_y : '0;
        end
        if (i_cmd.out_load) begin
            r_out_state     <= r_to;
            r_out_alpha     <= r_a;
            r_out_lik       <= r_res_lik;
            r_out_lik_valid <= r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_lik       <= NEG_INF;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.finish) begin
                r_res_valid <= r_final && i_cmd.is_last;
                if (r_final) begin
                    r_lik <= i_cmd.is_last ? NEG_INF : sum_y;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_out_state;
    assign o_alpha     = r_out_alpha;
    assign o_lik       = r_out_lik;
    assign o_lik_valid = r_out_lik_valid;

endmodule
